// ===== design/lpi_pkg.sv =====
// Shared constants, types and helpers for the line-plane intersection unit.
`default_nettype none

package lpi_pkg;

  // Field formats
  localparam int POS_W           = 32;                  // positions, 1/256 mm
  localparam int SLOPE_FRAC_BITS = 20;                  // slope fraction bits
  localparam int SLOPE_W         = SLOPE_FRAC_BITS + 4; // Q4.f slopes
  localparam int NORM_W          = 18;                  // Q1.16 normal components
  localparam int LIMIT_W         = 16;

  // Configuration port
  localparam int CFG_W     = (POS_W > NORM_W) ? POS_W : NORM_W;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int DIFF_W = POS_W + 1;                    // plane point minus offset
  localparam int NUM_W  = DIFF_W + NORM_W + 2;          // exact numerator
  localparam int DEN_W  = SLOPE_W + NORM_W + 2;         // exact denominator
  localparam int FAC_W  = SLOPE_W;                      // slope magnitude
  localparam int NLO_W  = (NUM_W + 1) / 2;              // numerator split for products
  localparam int NHI_W  = NUM_W - NLO_W;
  localparam int DVD_W  = NUM_W + FAC_W;                // dividend
  localparam int QUO_W  = POS_W + 1;                    // exact quotient bits kept
  localparam int HI_W   = DVD_W - QUO_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

  // Mid queue; depth must be a power of two
  localparam int MQ_DEPTH  = 4;
  localparam int MQ_PTR_W  = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);

  localparam logic signed [NORM_W-1:0]  NORMAL_Z_RST = NORM_W'(65536);
  localparam logic [LIMIT_W-1:0]        LIMIT_RST    = LIMIT_W'(1);
  localparam logic [FAC_W-1:0]          Z_FAC        =
    FAC_W'({1'b1, {SLOPE_FRAC_BITS{1'b0}}});
  localparam logic signed [POS_W-1:0]   POS_MAX      = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]   POS_MIN      = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_HIT      = 2'd0,
    STATUS_PARALLEL = 2'd1,
    STATUS_BEHIND   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_X        = 3'd0,
    REG_PLANE_Y        = 3'd1,
    REG_PLANE_Z        = 3'd2,
    REG_NORMAL_X       = 3'd3,
    REG_NORMAL_Y       = 3'd4,
    REG_NORMAL_Z       = 3'd5,
    REG_PARALLEL_LIMIT = 3'd6
  } cfg_reg_t;

  // Classified track, front to back
  typedef struct packed {
    status_t                   status;
    logic [NUM_W-1:0]          num_mag;
    logic [DEN_W-1:0]          den_mag;
    logic signed [POS_W-1:0]   base_x;
    logic signed [POS_W-1:0]   base_y;
    logic                      neg_x;
    logic                      neg_y;
    logic [FAC_W-1:0]          mag_x;
    logic [FAC_W-1:0]          mag_y;
  } mid_t;

  // What rides alongside the dividers
  typedef struct packed {
    status_t                   status;
    logic signed [POS_W-1:0]   base_x;
    logic signed [POS_W-1:0]   base_y;
    logic                      neg_x;
    logic                      neg_y;
  } side_t;

  typedef struct packed {
    status_t                   status;
    logic signed [POS_W-1:0]   hit_x;
    logic signed [POS_W-1:0]   hit_y;
    logic signed [POS_W-1:0]   hit_z;
  } res_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+2:0] v);
    logic signed [POS_W+2:0] hi_lim;
    logic signed [POS_W+2:0] lo_lim;
    hi_lim = (POS_W+3)'(POS_MAX);
    lo_lim = (POS_W+3)'(POS_MIN);
    if (v > hi_lim) begin
      return POS_MAX;
    end else if (v < lo_lim) begin
      return POS_MIN;
    end
    return v[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/lpi_front.sv =====
// Front end: configuration registers, numerator/denominator and classification.
`default_nettype none

module lpi_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [lpi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lpi_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [lpi_pkg::POS_W-1:0]      offset_x,
  input  logic signed [lpi_pkg::POS_W-1:0]      offset_y,
  input  logic signed [lpi_pkg::SLOPE_W-1:0]    slope_x,
  input  logic signed [lpi_pkg::SLOPE_W-1:0]    slope_y,
  output logic                                  q_push,
  output lpi_pkg::mid_t                         q_entry,
  input  logic                                  q_full
);
  import lpi_pkg::*;

  localparam int PX_W  = DIFF_W + NORM_W;
  localparam int PZ_W  = POS_W + NORM_W;
  localparam int KN_W  = SLOPE_W + NORM_W;
  localparam int NZS_W = NORM_W + SLOPE_FRAC_BITS;

  // configuration
  logic signed [POS_W-1:0]  plane_x, plane_y, plane_z;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic [LIMIT_W-1:0]       parallel_limit;

  // pipeline
  logic                     en;
  logic                     v1, v2, v3, v4;
  logic signed [POS_W-1:0]  bx1, by1, bx2, by2, bx3, by3;
  logic signed [SLOPE_W-1:0] kx1, ky1, kx2, ky2, kx3, ky3;
  logic signed [DIFF_W-1:0] dx1, dy1;
  logic signed [PX_W-1:0]   px2, py2;
  logic signed [PZ_W-1:0]   pz2;
  logic signed [KN_W-1:0]   kxn2, kyn2;
  logic signed [NZS_W-1:0]  nzs2;
  logic signed [NUM_W-1:0]  num3;
  logic signed [DEN_W-1:0]  den3;
  mid_t                     cls, entry4;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_x        <= '0;
      plane_y        <= '0;
      plane_z        <= '0;
      normal_x       <= '0;
      normal_y       <= '0;
      normal_z       <= NORMAL_Z_RST;
      parallel_limit <= LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PLANE_X:        plane_x        <= cfg_data[POS_W-1:0];
        REG_PLANE_Y:        plane_y        <= cfg_data[POS_W-1:0];
        REG_PLANE_Z:        plane_z        <= cfg_data[POS_W-1:0];
        REG_NORMAL_X:       normal_x       <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Y:       normal_y       <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Z:       normal_z       <= cfg_data[NORM_W-1:0];
        REG_PARALLEL_LIMIT: parallel_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // whole front moves together; holds only when the last stage cannot push
  assign en     = !(v4 && q_full);
  assign full   = !en;
  assign q_push = v4 && !q_full;
  assign q_entry = entry4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // classification of the summed terms
  always_comb begin
    logic den_neg;
    logic num_neg;
    den_neg = den3[DEN_W-1];
    num_neg = num3[NUM_W-1];
    cls.den_mag = den_neg ? DEN_W'(-den3) : DEN_W'(den3);
    cls.num_mag = num_neg ? NUM_W'(-num3) : NUM_W'(num3);
    if (den3 == '0 || cls.den_mag < DEN_W'(parallel_limit)) begin
      cls.status = STATUS_PARALLEL;
    end else if (num3 != '0 && num_neg != den_neg) begin
      cls.status = STATUS_BEHIND;
    end else begin
      cls.status = STATUS_HIT;
    end
    cls.base_x = bx3;
    cls.base_y = by3;
    cls.neg_x  = kx3[SLOPE_W-1];
    cls.neg_y  = ky3[SLOPE_W-1];
    cls.mag_x  = kx3[SLOPE_W-1] ? FAC_W'(-kx3) : FAC_W'(kx3);
    cls.mag_y  = ky3[SLOPE_W-1] ? FAC_W'(-ky3) : FAC_W'(ky3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: differences
      bx1 <= offset_x;
      by1 <= offset_y;
      kx1 <= slope_x;
      ky1 <= slope_y;
      dx1 <= DIFF_W'(plane_x) - DIFF_W'(offset_x);
      dy1 <= DIFF_W'(plane_y) - DIFF_W'(offset_y);
      // stage 2: products
      bx2  <= bx1;
      by2  <= by1;
      kx2  <= kx1;
      ky2  <= ky1;
      px2  <= PX_W'(dx1) * PX_W'(normal_x);
      py2  <= PX_W'(dy1) * PX_W'(normal_y);
      pz2  <= PZ_W'(plane_z) * PZ_W'(normal_z);
      kxn2 <= KN_W'(kx1) * KN_W'(normal_x);
      kyn2 <= KN_W'(ky1) * KN_W'(normal_y);
      nzs2 <= $signed({normal_z, {SLOPE_FRAC_BITS{1'b0}}});
      // stage 3: sums
      bx3  <= bx2;
      by3  <= by2;
      kx3  <= kx2;
      ky3  <= ky2;
      num3 <= NUM_W'(px2) + NUM_W'(py2) + NUM_W'(pz2);
      den3 <= DEN_W'(kxn2) + DEN_W'(kyn2) + DEN_W'(nzs2);
      // stage 4: classified entry
      entry4 <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== design/lpi_queue.sv =====
// Short queue between the front and the back.
`default_nettype none

module lpi_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpi_pkg::mid_t  push_data,
  output logic           full,
  input  logic           pop,
  output lpi_pkg::mid_t  pop_data,
  output logic           empty
);
  import lpi_pkg::*;

  mid_t                 mem [MQ_DEPTH];
  logic [MQ_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [MQ_CNT_W-1:0]  count;
  logic                 do_push, do_pop;

  assign full     = (count == MQ_CNT_W'(MQ_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/lpi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, clamped quotient.
`default_nettype none

module lpi_divider (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lpi_pkg::DVD_W-1:0]    dividend,
  input  logic [lpi_pkg::DEN_W-1:0]    divisor,
  output logic [lpi_pkg::QUO_W:0]      quotient
);
  import lpi_pkg::*;

  logic [DEN_W-1:0] rem  [0:QUO_W];
  logic [QUO_W-1:0] low  [0:QUO_W];
  logic [QUO_W-1:0] quo  [0:QUO_W];
  logic [DEN_W-1:0] dvs  [0:QUO_W];
  logic             ovf  [0:QUO_W];
  logic [HI_W-1:0]  hi;
  logic             ovf0;

  // quotient reaches 2^QUO_W exactly when the top part is not below the divisor
  assign hi   = dividend[DVD_W-1:QUO_W];
  assign ovf0 = (CMP_W'(hi) >= CMP_W'(divisor));

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ovf0 ? '0 : DEN_W'(hi);
      low[0] <= dividend[QUO_W-1:0];
      quo[0] <= '0;
      dvs[0] <= divisor;
      ovf[0] <= ovf0;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem[i-1], low[i-1][QUO_W-1]};
      ge    = (trial >= {1'b0, dvs[i-1]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? DEN_W'(trial - {1'b0, dvs[i-1]}) : DEN_W'(trial);
        low[i] <= {low[i-1][QUO_W-2:0], 1'b0};
        quo[i] <= {quo[i-1][QUO_W-2:0], ge};
        dvs[i] <= dvs[i-1];
        ovf[i] <= ovf[i-1];
      end
    end
  end

  assign quotient = ovf[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo[QUO_W]};

endmodule

`default_nettype wire

// ===== design/lpi_back.sv =====
// Back end: scaling products, three dividers, saturation and result buffer.
`default_nettype none

module lpi_back (
  input  logic           clk,
  input  logic           rst,
  input  lpi_pkg::mid_t  q_entry,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output lpi_pkg::res_t  result
);
  import lpi_pkg::*;

  localparam int PLO_W = NLO_W + FAC_W;
  localparam int PHI_W = NHI_W + FAC_W;

  logic                en;
  logic                v0, v1, v2;
  mid_t                b0;
  side_t               sb1, sb2;
  logic [FAC_W-1:0]    fac [3];
  logic [PLO_W-1:0]    plo [3];
  logic [PHI_W-1:0]    phi [3];
  logic [DEN_W-1:0]    den1, den2;
  logic [DVD_W-1:0]    dvd [3];
  logic [QUO_W:0]      quo [3];
  side_t               sbd [0:QUO_W];
  logic                vd  [0:QUO_W];
  res_t                res_c;

  // result buffer
  res_t                ob [2];
  logic                ob_wr, ob_rd;
  logic [1:0]          ob_cnt;
  logic                ob_push, ob_pop;

  assign en    = (ob_cnt != 2'd2);
  assign q_pop = en && !q_empty;

  assign fac[0] = b0.mag_x;
  assign fac[1] = b0.mag_y;
  assign fac[2] = Z_FAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= !q_empty;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= q_entry;
      sb1.status <= b0.status;
      sb1.base_x <= b0.base_x;
      sb1.base_y <= b0.base_y;
      sb1.neg_x  <= b0.neg_x;
      sb1.neg_y  <= b0.neg_y;
      den1 <= b0.den_mag;
      sb2  <= sb1;
      den2 <= den1;
      for (int l = 0; l < 3; l++) begin
        plo[l] <= PLO_W'(b0.num_mag[NLO_W-1:0]) * PLO_W'(fac[l]);
        phi[l] <= PHI_W'(b0.num_mag[NUM_W-1:NLO_W]) * PHI_W'(fac[l]);
        dvd[l] <= (DVD_W'(phi[l]) << NLO_W) + DVD_W'(plo[l]);
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    lpi_divider u_div (
      .clk      (clk),
      .en       (en),
      .dividend (dvd[l]),
      .divisor  (den2),
      .quotient (quo[l])
    );
  end

  // sideband follows the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QUO_W; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= v2;
      for (int i = 1; i <= QUO_W; i++) begin
        vd[i] <= vd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= sb2;
      for (int i = 1; i <= QUO_W; i++) begin
        sbd[i] <= sbd[i-1];
      end
    end
  end

  always_comb begin
    logic signed [POS_W+2:0] qx, qy, qz;
    logic signed [POS_W+2:0] sx, sy;
    qx = $signed({1'b0, quo[0]});
    qy = $signed({1'b0, quo[1]});
    qz = $signed({1'b0, quo[2]});
    sx = sbd[QUO_W].neg_x ? (POS_W+3)'(sbd[QUO_W].base_x) - qx
                          : (POS_W+3)'(sbd[QUO_W].base_x) + qx;
    sy = sbd[QUO_W].neg_y ? (POS_W+3)'(sbd[QUO_W].base_y) - qy
                          : (POS_W+3)'(sbd[QUO_W].base_y) + qy;
    res_c.status = sbd[QUO_W].status;
    if (sbd[QUO_W].status == STATUS_HIT) begin
      res_c.hit_x = sat_pos(sx);
      res_c.hit_y = sat_pos(sy);
      res_c.hit_z = sat_pos(qz);
    end else begin
      res_c.hit_x = '0;
      res_c.hit_y = '0;
      res_c.hit_z = '0;
    end
  end

  assign ob_push = en && vd[QUO_W];
  assign ob_pop  = pop && (ob_cnt != 2'd0);
  assign empty   = (ob_cnt == 2'd0);
  assign result  = ob[ob_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wr <= !ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= !ob_rd;
      end
      case ({ob_push, ob_pop})
        2'b10:   ob_cnt <= ob_cnt + 2'd1;
        2'b01:   ob_cnt <= ob_cnt - 2'd1;
        default: ob_cnt <= ob_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob[ob_wr] <= res_c;
    end
  end

endmodule

`default_nettype wire

// ===== design/line_plane_intersection_unit.sv =====
// Top level of the line-plane intersection unit.
`default_nettype none

// Channel   Handshake          Beat carries
// -------   ----------------   -------------------------------------------------
// track     push / full        offset_x, offset_y, slope_x, slope_y
// hit       empty / pop        status, hit_x, hit_y, hit_z
// config    cfg_write          cfg_index, cfg_data (no wait, no read-back)
//
// One track beat per cycle sustained while full stays low; each beat gives exactly one hit beat.
// From accept to the result showing, a track passes 4 front stages, the mid
// queue, 3 back stages, then the POS_W + 2 stage dividers, one quotient bit
// per stage, and the result buffer.
// Synchronous active-high reset clears all valid bits and loads the register
// defaults (unrotated plane at the origin, parallel limit 1).
// A stalled pop fills the 2-entry result buffer and freezes the back; the
// 4-deep mid queue then absorbs the front before full rises.

module line_plane_intersection_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // track input
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [lpi_pkg::POS_W-1:0]      offset_x,
  input  logic signed [lpi_pkg::POS_W-1:0]      offset_y,
  input  logic signed [lpi_pkg::SLOPE_W-1:0]    slope_x,
  input  logic signed [lpi_pkg::SLOPE_W-1:0]    slope_y,
  // hit output
  output logic                                  empty,
  input  logic                                  pop,
  output logic [1:0]                            status,
  output logic signed [lpi_pkg::POS_W-1:0]      hit_x,
  output logic signed [lpi_pkg::POS_W-1:0]      hit_y,
  output logic signed [lpi_pkg::POS_W-1:0]      hit_z,
  // configuration
  input  logic                                  cfg_write,
  input  logic [lpi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lpi_pkg::CFG_W-1:0]             cfg_data
);
  import lpi_pkg::*;

  logic   mq_push, mq_full, mq_pop, mq_empty;
  mid_t   mq_in, mq_out;
  res_t   result;

  // Front: config registers, den/num sums and parallel/behind classification
  lpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .slope_x   (slope_x),
    .slope_y   (slope_y),
    .q_push    (mq_push),
    .q_entry   (mq_in),
    .q_full    (mq_full)
  );

  // Decouples the two halves so each stalls on its own
  lpi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (mq_push),
    .push_data (mq_in),
    .full      (mq_full),
    .pop       (mq_pop),
    .pop_data  (mq_out),
    .empty     (mq_empty)
  );

  // Back: |num|*|k| / |den| per coordinate, sign, saturation, result buffer
  lpi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_entry (mq_out),
    .q_empty (mq_empty),
    .q_pop   (mq_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // rejected tracks already carry zero coordinates from the back
  assign status = result.status;
  assign hit_x  = result.hit_x;
  assign hit_y  = result.hit_y;
  assign hit_z  = result.hit_z;

endmodule

`default_nettype wire

// ===== design/lpi_checker.sv =====
// Port-level checks for the line-plane intersection unit, bound to the top level.
`default_nettype none

module lpi_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  full,
  input logic                                  empty,
  input logic                                  pop,
  input logic [1:0]                            status,
  input logic signed [lpi_pkg::POS_W-1:0]      hit_x,
  input logic signed [lpi_pkg::POS_W-1:0]      hit_y,
  input logic signed [lpi_pkg::POS_W-1:0]      hit_z
);
  import lpi_pkg::*;

  // nothing left in flight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting straight after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked straight after reset");

  // rejected tracks report zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != STATUS_HIT) |-> (hit_x == '0 && hit_y == '0 && hit_z == '0))
    else $error("rejected track with non-zero coordinates");

  // a hit lies in front of the track origin
  a_hit_ahead: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == STATUS_HIT) |-> !hit_z[POS_W-1])
    else $error("hit with negative z");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(hit_x)
                          && $stable(hit_y) && $stable(hit_z)))
    else $error("waiting result changed before pop");

endmodule

bind line_plane_intersection_unit lpi_checker u_lpi_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .status(status),
  .hit_x (hit_x),
  .hit_y (hit_y),
  .hit_z (hit_z)
);

`default_nettype wire
